[rtl/bdpc_pkg.sv]
// Shared types, constants and register codes for the button debounce press classifier.
`default_nettype none
package bdpc_pkg;

    localparam int unsigned FIELD_W            = 8;
    localparam int unsigned TICK_W             = 16;
    localparam int unsigned CHANNELS_DEFAULT   = 8;
    localparam int unsigned TIMER_BITS_DEFAULT = 16;
    localparam int unsigned APB_DATA_W         = 32;
    localparam int unsigned APB_ADDR_W         = 4;

    localparam logic [TICK_W-1:0]  DEBOUNCE_RESET   = 16'd10;
    localparam logic [TICK_W-1:0]  LONG_PRESS_RESET = 16'd500;
    localparam logic [FIELD_W-1:0] POLARITY_RESET   = 8'd0;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_ACTIVE_LOW = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_press_ticks;
    } lane_cfg_t;

    typedef struct packed {
        logic pressed;
        logic short_pulse;
        logic long_pulse;
    } lane_res_t;

endpackage
`default_nettype wire

[rtl/bdpc_lane.sv]
// One channel: saturating elapsed counter, debounce and short/long press detection.
`default_nettype none
module bdpc_lane #(
    parameter int unsigned TIMER_BITS = bdpc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire logic                raw,
    input  wire logic                polarity,
    input  wire bdpc_pkg::lane_cfg_t cfg,
    output bdpc_pkg::lane_res_t      res
);

    localparam int unsigned CMP_W =
        (TIMER_BITS > bdpc_pkg::TICK_W) ? TIMER_BITS : bdpc_pkg::TICK_W;

    logic                  raw_prev_reg,    raw_prev_next;
    logic                  stable_prev_reg, stable_prev_next;
    logic                  pressed_reg,     pressed_next;
    logic                  short_done_reg,  short_done_next;
    logic                  long_done_reg,   long_done_next;
    logic [TIMER_BITS-1:0] elapsed_reg,     elapsed_next;

    logic [CMP_W-1:0] t_ext;
    logic             short_pulse;
    logic             long_pulse;

    always_comb begin
        raw_prev_next    = raw;
        stable_prev_next = stable_prev_reg;
        pressed_next     = pressed_reg;
        short_done_next  = short_done_reg;
        long_done_next   = long_done_reg;
        short_pulse      = 1'b0;
        long_pulse       = 1'b0;

        // restart on a level change, otherwise count up and saturate
        if (raw != raw_prev_reg) begin
            elapsed_next = '0;
        end else if (elapsed_reg != {TIMER_BITS{1'b1}}) begin
            elapsed_next = elapsed_reg + TIMER_BITS'(1);
        end else begin
            elapsed_next = elapsed_reg;
        end
        t_ext = CMP_W'(elapsed_next);

        if (t_ext > CMP_W'(cfg.debounce_ticks)) begin
            if (stable_prev_reg == polarity && raw == !polarity) begin
                pressed_next = 1'b1;
            end
            if (stable_prev_reg == !polarity && raw == polarity) begin
                pressed_next    = 1'b0;
                short_done_next = 1'b0;
                long_done_next  = 1'b0;
            end
            stable_prev_next = raw;
        end

        if (!short_done_next) begin
            short_pulse     = pressed_next && (t_ext <= CMP_W'(cfg.long_press_ticks));
            short_done_next = short_pulse;
        end
        if (!long_done_next) begin
            long_pulse     = pressed_next && (t_ext > CMP_W'(cfg.long_press_ticks));
            long_done_next = long_pulse;
        end

        res.pressed     = pressed_next;
        res.short_pulse = short_pulse;
        res.long_pulse  = long_pulse;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_prev_reg    <= 1'b0;
            stable_prev_reg <= 1'b0;
            pressed_reg     <= 1'b0;
            short_done_reg  <= 1'b0;
            long_done_reg   <= 1'b0;
            elapsed_reg     <= '0;
        end else if (advance) begin
            raw_prev_reg    <= raw_prev_next;
            stable_prev_reg <= stable_prev_next;
            pressed_reg     <= pressed_next;
            short_done_reg  <= short_done_next;
            long_done_reg   <= long_done_next;
            elapsed_reg     <= elapsed_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bdpc_merge.sv]
// Gathers lane results into the output masks and holds them in the output register.
`default_nettype none
module bdpc_merge #(
    parameter int unsigned CHANNELS = bdpc_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire bdpc_pkg::lane_res_t          res [CHANNELS],
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [bdpc_pkg::FIELD_W-1:0]      m_pressed_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]      m_short_press_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]      m_long_press_mask
);

    localparam int unsigned FW = bdpc_pkg::FIELD_W;

    logic          valid_reg;
    logic          valid_next;
    logic [FW-1:0] pressed_reg, pressed_next;
    logic [FW-1:0] short_reg,   short_next;
    logic [FW-1:0] long_reg,    long_next;
    logic          advance;

    // only the low channels reach the result fields
    for (genvar j = 0; j < FW; j++) begin : g_pack
        if (j < CHANNELS) begin : g_lane
            assign pressed_next[j] = res[j].pressed;
            assign short_next[j]   = res[j].short_pulse;
            assign long_next[j]    = res[j].long_pulse;
        end else begin : g_pad
            assign pressed_next[j] = 1'b0;
            assign short_next[j]   = 1'b0;
            assign long_next[j]    = 1'b0;
        end
    end

    assign s_ready = !valid_reg || m_ready;
    assign advance = s_valid && s_ready;

    always_comb begin
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pressed_reg <= pressed_next;
            short_reg   <= short_next;
            long_reg    <= long_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_pressed_mask     = pressed_reg;
    assign m_short_press_mask = short_reg;
    assign m_long_press_mask  = long_reg;

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("accepted item produced no result");

    a_pulses_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_short_press_mask & m_long_press_mask) == '0))
        else $error("short and long pulse on the same channel");

    a_pulse_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_short_press_mask | m_long_press_mask) & ~m_pressed_mask) == '0))
        else $error("press pulse on a released channel");

endmodule
`default_nettype wire

[rtl/button_debounce_press_classifier_core.sv]
// Button debounce and short/long press classifier: top level with register port.
//
// Usage:
//   Each input item is one millisecond tick carrying the raw pin levels in
//   s_pin_levels (one bit per channel). Every item yields exactly one result
//   on the m_ channel: the debounced pressed mask and one-tick short-press and
//   long-press pulse masks.
//   m_valid rises in the cycle after acceptance; throughput is one item per
//   cycle while results are taken, set by the per-channel lane state update.
//   All channels run in parallel lanes; a merge stage packs their results.
//   When the receiver stalls, the result waits in the output register and
//   s_ready drops until it is taken; s_ready is high whenever that register
//   is empty or being emptied in the same cycle.
//   Reset (aresetn low, synchronous) clears all channel state and loads the
//   register defaults: debounce 10 ticks, long press 500 ticks, polarity 0.
//   Registers (APB, byte address 4*i): 0 debounce_ticks, 1 long_press_ticks,
//   2 active_low_mask. Write them only while the block is idle.
`default_nettype none
module button_debounce_press_classifier_core #(
    parameter int unsigned CHANNELS   = bdpc_pkg::CHANNELS_DEFAULT,
    parameter int unsigned TIMER_BITS = bdpc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bdpc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bdpc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bdpc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [bdpc_pkg::FIELD_W-1:0]       s_pin_levels,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [bdpc_pkg::FIELD_W-1:0]            m_pressed_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]            m_short_press_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]            m_long_press_mask
);

    localparam int unsigned FW = bdpc_pkg::FIELD_W;
    localparam int unsigned TW = bdpc_pkg::TICK_W;
    localparam int unsigned DW = bdpc_pkg::APB_DATA_W;

    logic [TW-1:0] debounce_reg, debounce_next;
    logic [TW-1:0] long_reg,     long_next;
    logic [FW-1:0] polarity_reg, polarity_next;

    bdpc_pkg::reg_index_t  reg_sel;
    bdpc_pkg::lane_cfg_t   cfg;
    bdpc_pkg::lane_res_t   res [CHANNELS];
    logic                  wr_en;
    logic                  advance;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = bdpc_pkg::reg_index_t'(paddr[3:2]);

    always_comb begin
        debounce_next = debounce_reg;
        long_next     = long_reg;
        polarity_next = polarity_reg;
        if (wr_en) begin
            case (reg_sel)
                bdpc_pkg::REG_DEBOUNCE:   debounce_next = pwdata[TW-1:0];
                bdpc_pkg::REG_LONG_PRESS: long_next     = pwdata[TW-1:0];
                bdpc_pkg::REG_ACTIVE_LOW: polarity_next = pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            bdpc_pkg::REG_DEBOUNCE:   prdata = DW'(debounce_reg);
            bdpc_pkg::REG_LONG_PRESS: prdata = DW'(long_reg);
            bdpc_pkg::REG_ACTIVE_LOW: prdata = DW'(polarity_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bdpc_pkg::DEBOUNCE_RESET;
            long_reg     <= bdpc_pkg::LONG_PRESS_RESET;
            polarity_reg <= bdpc_pkg::POLARITY_RESET;
        end else begin
            debounce_reg <= debounce_next;
            long_reg     <= long_next;
            polarity_reg <= polarity_next;
        end
    end

    assign cfg.debounce_ticks   = debounce_reg;
    assign cfg.long_press_ticks = long_reg;
    assign advance              = s_valid && s_ready;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        logic raw_bit;
        logic pol_bit;
        // channels beyond the pin field see level 0 and polarity 0
        if (i < FW) begin : g_pin
            assign raw_bit = s_pin_levels[i];
            assign pol_bit = polarity_reg[i];
        end else begin : g_tie
            assign raw_bit = 1'b0;
            assign pol_bit = 1'b0;
        end

        bdpc_lane #(
            .TIMER_BITS (TIMER_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .raw      (raw_bit),
            .polarity (pol_bit),
            .cfg      (cfg),
            .res      (res[i])
        );
    end

    bdpc_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .res                (res),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pressed_mask     (m_pressed_mask),
        .m_short_press_mask (m_short_press_mask),
        .m_long_press_mask  (m_long_press_mask)
    );

endmodule
`default_nettype wire
